// ----- hdl/spp_pkg.sv -----
// Shared types and constants for the space packet header parser.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package spp_pkg;

  // Packet layout.
  localparam int unsigned PRIMARY_SIZE = 6;
  localparam int unsigned TC_SEC_SIZE  = 5;
  localparam int unsigned TM_SEC_SIZE  = 15;
  localparam int unsigned KEEP_BYTES   = 11;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned MAX_PAYLOAD  = 1024;
  localparam int unsigned PUS_VERSION  = 2;
  localparam int unsigned SFLAGS_ALONE = 3;

  // Configuration register indexes (address bit 2 selects the register).
  localparam logic REG_PARSE_EN = 1'b0;
  localparam logic REG_CHECK_EN = 1'b1;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_SHORT      = 4'd1,
    ST_VERSION    = 4'd2,
    ST_TM_SHORT   = 4'd3,
    ST_TC_SHORT   = 4'd4,
    ST_NO_SEC_HDR = 4'd5,
    ST_SEQ_FLAGS  = 4'd6,
    ST_LEN_FIELD  = 4'd7,
    ST_TOO_LARGE  = 4'd8
  } status_e;

  typedef struct packed {
    logic parse_en;
    logic check_en;
  } cfg_t;

  typedef struct packed {
    status_e       status;
    logic          tc;
    logic [10:0]   apid;
    logic [13:0]   seq;
    logic [7:0]    svc;
    logic [7:0]    msg;
    logic [15:0]   src;
    logic [10:0]   size;
  } summary_t;

  // Results caused by one request: an optional payload byte, then an
  // optional end-of-packet summary.
  typedef struct packed {
    logic          pay_valid;
    logic [7:0]    pay_byte;
    logic          pay_run_end;
    logic          sum_valid;
    summary_t      sum;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/spp_cfg.sv -----
// Configuration registers behind an APB-style port.
// Depends on spp_pkg for the register indexes and the cfg_t type.
`default_nettype none

module spp_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output spp_pkg::cfg_t     cfg_o
);

  logic parse_en_q, parse_en_d;
  logic check_en_q, check_en_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode.
  always_comb begin
    parse_en_d = parse_en_q;
    check_en_d = check_en_q;
    if (wr_en) begin
      case (paddr[2])
        spp_pkg::REG_PARSE_EN: parse_en_d = pwdata[0];
        spp_pkg::REG_CHECK_EN: check_en_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_en_q <= 1'b1;
      check_en_q <= 1'b1;
    end else begin
      parse_en_q <= parse_en_d;
      check_en_q <= check_en_d;
    end
  end

  // Read data.
  always_comb begin
    case (paddr[2])
      spp_pkg::REG_PARSE_EN: prdata = {31'd0, parse_en_q};
      spp_pkg::REG_CHECK_EN: prdata = {31'd0, check_en_q};
      default:               prdata = 32'd0;
    endcase
  end

  assign cfg_o.parse_en = parse_en_q;
  assign cfg_o.check_en = check_en_q;

endmodule

`default_nettype wire

// ----- hdl/spp_core.sv -----
// Byte counter, kept header bytes and header decode for one packet byte.
// Depends on spp_pkg for layout constants, status codes and result types.
`default_nettype none

module spp_core #(
  parameter int unsigned MAX_PAYLOAD = spp_pkg::MAX_PAYLOAD
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      packet_byte_i,
  input  wire logic            end_of_packet_i,
  input  wire spp_pkg::cfg_t   cfg_i,
  output spp_pkg::result_t     res_o
);

  localparam int unsigned KB = spp_pkg::KEEP_BYTES;
  localparam int unsigned CW = spp_pkg::COUNT_W;
  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  logic [CW-1:0] count_q, count_d, count_w;
  logic [7:0]    hdr_q [KB];
  logic [7:0]    hdr_d [KB];
  logic [7:0]    hdr_w [KB];
  logic [7:0]    first_byte;
  logic [CW-1:0] hdr_end;
  logic          is_payload;

  spp_pkg::summary_t sum;
  logic [CW-1:0]     ecss;
  logic [15:0]       dlen;

  // Header bytes and count as they stand once this byte is taken in.
  always_comb begin
    for (int i = 0; i < KB; i++) begin
      hdr_w[i] = (count_q == CW'(i)) ? packet_byte_i : hdr_q[i];
    end
    count_w = (count_q == COUNT_MAX) ? count_q : count_q + CW'(1);
  end

  // A byte is payload once the primary and secondary headers have gone by.
  assign first_byte = (count_q == '0) ? packet_byte_i : hdr_q[0];
  assign hdr_end    = first_byte[4] ?
                      CW'(spp_pkg::PRIMARY_SIZE + spp_pkg::TC_SEC_SIZE) :
                      CW'(spp_pkg::PRIMARY_SIZE + spp_pkg::TM_SEC_SIZE);
  assign is_payload = (count_q >= hdr_end);

  // State update; the end of a packet clears everything.
  always_comb begin
    count_d = count_q;
    for (int i = 0; i < KB; i++) hdr_d[i] = hdr_q[i];
    if (accept_i) begin
      if (end_of_packet_i) begin
        count_d = '0;
        for (int i = 0; i < KB; i++) hdr_d[i] = 8'd0;
      end else begin
        count_d = count_w;
        for (int i = 0; i < KB; i++) hdr_d[i] = hdr_w[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < KB; i++) hdr_q[i] <= 8'd0;
    end else begin
      count_q <= count_d;
      for (int i = 0; i < KB; i++) hdr_q[i] <= hdr_d[i];
    end
  end

  // Summary decode; the first failing check sets the status.
  assign ecss = count_w - CW'(spp_pkg::PRIMARY_SIZE);
  assign dlen = {hdr_w[4], hdr_w[5]};

  always_comb begin
    sum = '0;
    sum.status = spp_pkg::ST_OK;
    if (count_w < CW'(spp_pkg::PRIMARY_SIZE)) begin
      sum.status = spp_pkg::ST_SHORT;
    end else if (!cfg_i.parse_en) begin
      sum.status = spp_pkg::ST_VERSION;
    end else begin
      sum.tc   = hdr_w[0][4];
      sum.apid = {hdr_w[0][2:0], hdr_w[1]};
      if (!sum.tc && (count_w < CW'(spp_pkg::TM_SEC_SIZE))) begin
        sum.status = spp_pkg::ST_TM_SHORT;
      end else if (sum.tc && (count_w < CW'(spp_pkg::TC_SEC_SIZE))) begin
        sum.status = spp_pkg::ST_TC_SHORT;
      end else if (cfg_i.check_en && (hdr_w[0][7:5] != 3'd0)) begin
        sum.status = spp_pkg::ST_VERSION;
      end else if (cfg_i.check_en && !hdr_w[0][3]) begin
        sum.status = spp_pkg::ST_NO_SEC_HDR;
      end else if (cfg_i.check_en && (hdr_w[2][7:6] != 2'(spp_pkg::SFLAGS_ALONE))) begin
        sum.status = spp_pkg::ST_SEQ_FLAGS;
      end else begin
        sum.seq = {hdr_w[2][5:0], hdr_w[3]};
        if (32'(dlen) > MAX_PAYLOAD) begin
          sum.status = spp_pkg::ST_LEN_FIELD;
        end else if (32'(ecss) > MAX_PAYLOAD) begin
          sum.status = spp_pkg::ST_TOO_LARGE;
        end else if (sum.tc) begin
          if (ecss < CW'(spp_pkg::TC_SEC_SIZE)) begin
            sum.status = spp_pkg::ST_TC_SHORT;
          end else if (hdr_w[6][7:4] != 4'(spp_pkg::PUS_VERSION)) begin
            sum.status = spp_pkg::ST_VERSION;
          end else begin
            sum.svc  = hdr_w[7];
            sum.msg  = hdr_w[8];
            sum.src  = {hdr_w[9], hdr_w[10]};
            sum.size = ecss - CW'(spp_pkg::TC_SEC_SIZE);
          end
        end else begin
          if (ecss < CW'(spp_pkg::TM_SEC_SIZE)) begin
            sum.status = spp_pkg::ST_TM_SHORT;
          end else if (hdr_w[6][7:4] != 4'(spp_pkg::PUS_VERSION)) begin
            sum.status = spp_pkg::ST_VERSION;
          end else begin
            sum.svc  = hdr_w[7];
            sum.msg  = hdr_w[8];
            sum.size = ecss - CW'(spp_pkg::TM_SEC_SIZE);
          end
        end
      end
    end
  end

  // Results of this request.
  assign res_o.pay_valid   = accept_i & is_payload;
  assign res_o.pay_byte    = packet_byte_i;
  assign res_o.pay_run_end = ~end_of_packet_i;
  assign res_o.sum_valid   = accept_i & end_of_packet_i;
  assign res_o.sum         = sum;

endmodule

`default_nettype wire

// ----- hdl/spp_outq.sv -----
// Result register: holds the payload item and summary of one request and
// hands them out in order. Depends on spp_pkg for the result types.
`default_nettype none

module spp_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire spp_pkg::result_t res_i,
  output logic               load_ok_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               item_kind_o,
  output logic [7:0]         payload_byte_o,
  output logic [3:0]         status_o,
  output logic               is_telecommand_o,
  output logic [10:0]        application_id_o,
  output logic [13:0]        sequence_count_o,
  output logic [7:0]         service_type_o,
  output logic [7:0]         message_type_o,
  output logic [15:0]        source_id_o,
  output logic [10:0]        payload_size_o,
  output logic               run_end_o
);

  logic              pay_v_q, pay_v_d;
  logic              sum_v_q, sum_v_d;
  logic [7:0]        pay_byte_q;
  logic              pay_end_q;
  spp_pkg::summary_t sum_q;
  logic              pop;
  logic              load;

  assign out_valid_o = pay_v_q | sum_v_q;
  assign pop         = out_valid_o & ~out_stall_i;

  // A new request may enter when the register is empty after this cycle.
  assign load_ok_o = (~pay_v_q & ~sum_v_q) | (pop & ~(pay_v_q & sum_v_q));
  assign load      = res_i.pay_valid | res_i.sum_valid;

  // Valid bits: the payload item leaves before the summary.
  always_comb begin
    pay_v_d = pay_v_q;
    sum_v_d = sum_v_q;
    if (pop) begin
      if (pay_v_q) pay_v_d = 1'b0;
      else         sum_v_d = 1'b0;
    end
    if (load) begin
      pay_v_d = res_i.pay_valid;
      sum_v_d = res_i.sum_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pay_v_q <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      pay_v_q <= pay_v_d;
      sum_v_q <= sum_v_d;
    end
  end

  // Result data.
  always_ff @(posedge clk_i) begin
    if (load) begin
      pay_byte_q <= res_i.pay_byte;
      pay_end_q  <= res_i.pay_run_end;
      sum_q      <= res_i.sum;
    end
  end

  // Output select: payload item fields are zero except the byte itself and the run-end flag.
  always_comb begin
    if (pay_v_q) begin
      item_kind_o      = 1'b0;
      payload_byte_o   = pay_byte_q;
      status_o         = spp_pkg::ST_OK;
      is_telecommand_o = 1'b0;
      application_id_o = '0;
      sequence_count_o = '0;
      service_type_o   = '0;
      message_type_o   = '0;
      source_id_o      = '0;
      payload_size_o   = '0;
      run_end_o        = pay_end_q;
    end else begin
      item_kind_o      = 1'b1;
      payload_byte_o   = '0;
      status_o         = sum_q.status;
      is_telecommand_o = sum_q.tc;
      application_id_o = sum_q.apid;
      sequence_count_o = sum_q.seq;
      service_type_o   = sum_q.svc;
      message_type_o   = sum_q.msg;
      source_id_o      = sum_q.src;
      payload_size_o   = sum_q.size;
      run_end_o        = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/space_packet_header_parser.sv -----
// Top level of the space packet header parser.
// Depends on spp_pkg, spp_cfg, spp_core and spp_outq.
//
//   Channel  | Handshake                 | Contents
//   ---------+---------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o   | packet_byte_i, end_of_packet_i
//   out      | out_valid_o / out_stall_i | payload item or end-of-packet summary
//   config   | psel, penable, pwrite     | two 1-bit enables at 0x0 and 0x4
//
// Each byte is decoded in the cycle it is accepted and its results sit in the
// result register in the next cycle. One byte per cycle is taken while the
// output drains freely; the final byte of a packet whose last byte is payload
// yields two results and holds the input until the payload item leaves. Reset
// clears the byte count and kept header bytes and sets both enables. A stalled
// output stalls the input once the result register cannot empty in that cycle.
`default_nettype none

module space_packet_header_parser #(
  parameter int unsigned MAX_PAYLOAD = spp_pkg::MAX_PAYLOAD
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input bytes
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   packet_byte_i,
  input  wire logic         end_of_packet_i,
  // Results
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              item_kind_o,
  output logic [7:0]        payload_byte_o,
  output logic [3:0]        status_o,
  output logic              is_telecommand_o,
  output logic [10:0]       application_id_o,
  output logic [13:0]       sequence_count_o,
  output logic [7:0]        service_type_o,
  output logic [7:0]        message_type_o,
  output logic [15:0]       source_id_o,
  output logic [10:0]       payload_size_o,
  output logic              run_end_o
);

  spp_pkg::cfg_t    cfg;
  spp_pkg::result_t res;
  logic             load_ok;
  logic             accept;

  assign in_stall_o = ~load_ok;
  assign accept     = in_valid_i & load_ok;

  spp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .packet_byte_i   (packet_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .cfg_i           (cfg),
    .res_o           (res)
  );

  spp_outq u_outq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_i            (res),
    .load_ok_o        (load_ok),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .status_o         (status_o),
    .is_telecommand_o (is_telecommand_o),
    .application_id_o (application_id_o),
    .sequence_count_o (sequence_count_o),
    .service_type_o   (service_type_o),
    .message_type_o   (message_type_o),
    .source_id_o      (source_id_o),
    .payload_size_o   (payload_size_o),
    .run_end_o        (run_end_o)
  );

endmodule

`default_nettype wire
